@@ hw/rtl/oaht_pkg.sv @@
`timescale 1ns / 1ps
package oaht_pkg;
	localparam int TableSize = 1024;
	localparam int IdxW = $clog2(TableSize);
	localparam int CntW = IdxW + 1;
	localparam logic [31:0] SlotEmpty = 32'h0000_0000;
	localparam logic [31:0] SlotTomb = 32'hFFFF_FFFF;

	localparam logic [2:0] OpFind = 3'd0;
	localparam logic [2:0] OpInsert = 3'd1;
	localparam logic [2:0] OpRemove = 3'd2;
	localparam logic [2:0] OpNext = 3'd3;
	localparam logic [2:0] OpClear = 3'd4;

	localparam logic [2:0] StFound = 3'd0;
	localparam logic [2:0] StInserted = 3'd1;
	localparam logic [2:0] StRemoved = 3'd2;
	localparam logic [2:0] StNotFound = 3'd3;
	localparam logic [2:0] StInvalid = 3'd4;
	localparam logic [2:0] StFull = 3'd5;
	localparam logic [2:0] StEnd = 3'd6;

	typedef struct packed {
		logic we;
		logic [IdxW-1:0] waddr;
		logic [31:0] wdata;
		logic re;
		logic [IdxW-1:0] raddr;
	} mem_req_t;
endpackage

@@ hw/rtl/oaht_store.sv @@
`timescale 1ns / 1ps
module oaht_store (
	input logic clk,
	input oaht_pkg::mem_req_t req,
	output logic [31:0] rdata
);
	logic [31:0] mem [oaht_pkg::TableSize];

	always_ff @(posedge clk) begin
		if (req.we) mem[req.waddr] <= req.wdata;
		if (req.re) rdata <= mem[req.raddr];
	end
endmodule

@@ hw/rtl/open_address_hash_table.sv @@
`timescale 1ns / 1ps
// Open-address key table, probing by steps of 1, 4, 9, ... (p*p) with tombstones, 1024 slots.
// Input channel (valid/ready): opcode, key, start_index. Output channel
// (out_valid/out_ready): status, slot, key_out, live_count, one item per input.
// cfg_we/cfg_data write occupancy_limit; write only while idle.
// One item is worked on at a time. Each probe or scanned slot is a read state
// then a check state (synchronous key memory, one read and one write port).
// Find answers from the check state; insert or remove that writes the slot
// passes through a write state first; iteration scans slots the same way.
// A bad key, an unknown opcode or a start past the end answers without a memory read.
// Clear writes all 1024 slots, one per cycle, and then answers.
// The next item is taken in the idle state after the result is loaded, so a
// new item is not taken before the last one is through.
// After reset a clearing pass writes every slot empty, during which ready is
// low. The result waits in an output register while the next item is worked
// on; a second finished item holds the block (ready low) until the receiver
// takes the first.
module open_address_hash_table (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic ready,
	input logic [2:0] opcode,
	input logic signed [31:0] key,
	input logic [10:0] start_index,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] status,
	output logic [9:0] slot,
	output logic [30:0] key_out,
	output logic [10:0] live_count,
	input logic cfg_we,
	input logic [10:0] cfg_data
);
	localparam int IW = oaht_pkg::IdxW;
	localparam int CW = oaht_pkg::CntW;

	typedef enum logic [5:0] {
		S_CLR = 6'b000001, S_IDLE = 6'b000010, S_RD = 6'b000100,
		S_CHK = 6'b001000, S_WR = 6'b010000, S_OUT = 6'b100000
	} state_t;

	state_t state_q;
	oaht_pkg::mem_req_t req;
	logic [31:0] rdata;
	logic [2:0] op_q;
	logic [31:0] key_q;
	logic [IW-1:0] idx_q, tomb_idx_q;
	logic tomb_seen_q;
	logic [CW-1:0] p_q;
	logic [CW-1:0] live_q, tomb_q, limit_q;
	logic [IW-1:0] wr_idx_q;
	logic [31:0] wr_data_q;
	logic [IW:0] clr_q;
	logic [IW-1:0] sq_q;
	logic [2:0] st_q;
	logic [IW-1:0] slot_q;
	logic [30:0] kout_q;

	oaht_store u_store (.clk(clk), .req(req), .rdata(rdata));

	logic key_ok;
	assign key_ok = (key != 32'sd0) && !key[31];
	assign ready = (state_q == S_IDLE);

	always_comb begin
		req = '0;
		req.raddr = idx_q;
		req.re = (state_q == S_RD);
		if (state_q == S_CLR) begin
			req.we = 1'b1;
			req.waddr = clr_q[IW-1:0];
			req.wdata = oaht_pkg::SlotEmpty;
		end else if (state_q == S_WR) begin
			req.we = 1'b1;
			req.waddr = wr_idx_q;
			req.wdata = wr_data_q;
		end
	end

	// step p*p mod size advanced incrementally, added to the last index: (p+1)^2 = p^2 + 2p + 1
	logic [IW-1:0] nxt_idx;
	assign nxt_idx = idx_q + sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			op_q <= oaht_pkg::OpFind;
			clr_q <= '0;
			live_q <= '0;
			tomb_q <= '0;
			limit_q <= CW'(511);
			out_valid <= 1'b0;
			status <= '0;
			slot <= '0;
			key_out <= '0;
			live_count <= '0;
		end else begin
			if (cfg_we) limit_q <= cfg_data;
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					// a clear item answers; the pass after reset does not
					if (clr_q == (IW+1)'(oaht_pkg::TableSize - 1))
						state_q <= (op_q == oaht_pkg::OpClear) ? S_OUT : S_IDLE;
				end
				S_IDLE: if (valid) begin
					op_q <= opcode;
					key_q <= key;
					st_q <= oaht_pkg::StNotFound;
					slot_q <= '0;
					kout_q <= '0;
					p_q <= CW'(1);
					sq_q <= IW'(1);
					tomb_seen_q <= 1'b0;
					if (opcode <= oaht_pkg::OpRemove) begin
						idx_q <= key[IW-1:0];
						if (!key_ok) begin
							st_q <= oaht_pkg::StInvalid;
							state_q <= S_OUT;
						end else state_q <= S_RD;
					end else if (opcode == oaht_pkg::OpNext) begin
						idx_q <= start_index[IW-1:0];
						st_q <= oaht_pkg::StEnd;
						state_q <= start_index[IW] ? S_OUT : S_RD;
					end else if (opcode == oaht_pkg::OpClear) begin
						st_q <= oaht_pkg::StRemoved;
						live_q <= '0;
						tomb_q <= '0;
						clr_q <= '0;
						state_q <= S_CLR;
					end else state_q <= S_OUT;
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (op_q == oaht_pkg::OpNext) begin
						if (rdata != oaht_pkg::SlotEmpty && rdata != oaht_pkg::SlotTomb) begin
							st_q <= oaht_pkg::StFound;
							slot_q <= idx_q;
							kout_q <= rdata[30:0];
							state_q <= S_OUT;
						end else if (idx_q == IW'(oaht_pkg::TableSize - 1)) state_q <= S_OUT;
						else begin
							idx_q <= idx_q + 1'b1;
							state_q <= S_RD;
						end
					end else begin
						logic done, miss, t_ok;
						logic [IW-1:0] w;
						logic w_tomb;
						done = 1'b0;
						miss = 1'b0;
						t_ok = tomb_seen_q || rdata == oaht_pkg::SlotTomb;
						w = tomb_seen_q ? tomb_idx_q : idx_q;
						w_tomb = t_ok;
						if (rdata == key_q) begin
							done = 1'b1;
							if (op_q == oaht_pkg::OpRemove) begin
								st_q <= oaht_pkg::StRemoved;
								wr_idx_q <= idx_q;
								wr_data_q <= oaht_pkg::SlotTomb;
								tomb_q <= tomb_q + 1'b1;
								if (live_q != '0) live_q <= live_q - 1'b1;
								slot_q <= idx_q;
								state_q <= S_WR;
							end else begin
								st_q <= oaht_pkg::StFound;
								slot_q <= idx_q;
								state_q <= S_OUT;
							end
						end else if (rdata == oaht_pkg::SlotEmpty) begin
							done = 1'b1;
							miss = 1'b1;
							w_tomb = tomb_seen_q;
						end else if (p_q == CW'(oaht_pkg::TableSize)) begin
							done = 1'b1;
							miss = 1'b1;
						end
						if (rdata == oaht_pkg::SlotTomb && !tomb_seen_q) begin
							tomb_seen_q <= 1'b1;
							tomb_idx_q <= idx_q;
						end
						if (miss) begin
							state_q <= S_OUT;
							if (op_q == oaht_pkg::OpInsert) begin
								if ((rdata != oaht_pkg::SlotEmpty && !t_ok) ||
										({1'b0, live_q} + {1'b0, tomb_q} + 1'b1 >
										{1'b0, limit_q})) begin
									st_q <= oaht_pkg::StFull;
								end else begin
									st_q <= oaht_pkg::StInserted;
									slot_q <= w;
									wr_idx_q <= w;
									wr_data_q <= key_q;
									live_q <= live_q + 1'b1;
									if (w_tomb && tomb_q != '0) tomb_q <= tomb_q - 1'b1;
									state_q <= S_WR;
								end
							end
						end
						if (!done) begin
							idx_q <= nxt_idx;
							sq_q <= sq_q + IW'({p_q, 1'b1});
							p_q <= p_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_WR: state_q <= S_OUT;
				S_OUT: begin
					// load the output register once it is free or being taken
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						status <= st_q;
						slot <= slot_q;
						key_out <= kout_q;
						live_count <= live_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_wr_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WR |-> wr_data_q != oaht_pkg::SlotEmpty)
		else $error("slot write of empty marker");
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, live_q} + {1'b0, tomb_q} <= (CW+1)'(oaht_pkg::TableSize))
		else $error("count overflow");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped");
endmodule
